// ===== hdl/mnsp_pkg.sv =====
// Shared types, constants and command/status structs of the MIDI note span pairer.
package mnsp_pkg;

    localparam int MAX_SPANS         = 256;
    localparam int CHANNELS          = 16;
    localparam int NOTES_PER_CHANNEL = 128;
    localparam int TICK_BITS         = 24;

    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 16;
    localparam int TICK_W   = 24;
    localparam int END_W    = 25;
    localparam int LEN_W    = 2;
    localparam int STATUS_W = 8;
    localparam int CH_W     = 4;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 7;
    localparam int SLOT_W   = CH_W + NOTE_W;
    localparam int SLOTS    = 1 << SLOT_W;

    // valid bits are packed into words; one word covers VWORD_BITS slots
    localparam int VBIT_W     = 4;
    localparam int VWORD_BITS = 1 << VBIT_W;
    localparam int VADDR_W    = SLOT_W - VBIT_W;
    localparam int VWORDS     = 1 << VADDR_W;

    localparam int DATA_W = INDEX_W + TICK_W + VEL_W;
    localparam int SPAN_W = $clog2(MAX_SPANS + 1);

    localparam logic [TICK_W-1:0] TICK_MASK    = TICK_W'((64'd1 << TICK_BITS) - 64'd1);
    localparam logic [TICK_W-1:0] DEFAULT_LOOP = TICK_W'(96 * 4);

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_EVENT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;

    localparam logic [LEN_W-1:0]  MSG_LEN_FULL  = 2'd3;
    localparam logic [3:0]        KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0]        KIND_NOTE_OFF = 4'h8;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [INDEX_W-1:0]  event_index;
        logic [TICK_W-1:0]   tick;
        logic [LEN_W-1:0]    msg_len;
        logic [STATUS_W-1:0] status_byte;
        logic [NOTE_W-1:0]   data_one;
        logic [VEL_W-1:0]    data_two;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [INDEX_W-1:0]  on_index;
        logic [INDEX_W-1:0]  off_index;
        logic                off_implicit;
        logic [TICK_W-1:0]   start_tick;
        logic [END_W-1:0]    stop_tick;
        logic [CH_W-1:0]     channel;
        logic [NOTE_W-1:0]   note_number;
        logic [VEL_W-1:0]    velocity;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EV_READ,
        ST_EV_DONE,
        ST_SCAN_READ,
        ST_SCAN_CHECK,
        ST_FL_READ,
        ST_EMIT_SPAN,
        ST_EMIT_NONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic clear_start;
        logic sweep_wr;
        logic scan_next;
        logic rd_scan;
        logic slot_from_scan;
        logic note_on_wr;
        logic emit_span;
        logic emit_none;
    } t_cmd;

    typedef struct packed {
        logic [FUNC_W-1:0] in_func;
        logic              at_limit;
        logic              ev_ok;
        logic              note_on;
        logic              note_off;
        logic              slot_open;
        logic              word_hit;
        logic              scan_last;
        logic              sweep_last;
        logic              out_free;
    } t_stat;

endpackage

// ===== hdl/mnsp_in_if.sv =====
// Input item channel: valid, ready and the input item.
interface mnsp_in_if;
    logic                valid;
    logic                ready;
    mnsp_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/mnsp_out_if.sv =====
// Result item channel: valid, ready and the result item.
interface mnsp_out_if;
    logic                valid;
    logic                ready;
    mnsp_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/mnsp_cfg_if.sv =====
// Configuration write channel carrying the loop length.
interface mnsp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mnsp_pkg::TICK_W-1:0]     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/mnsp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module mnsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule

// ===== hdl/mnsp_datapath.sv =====
// Datapath: item and slot registers, open-note table, span count, end math, result register.
module mnsp_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mnsp_pkg::t_in_item          i_in_item,
    input  logic                        i_cfg_valid,
    input  logic [mnsp_pkg::TICK_W-1:0] i_cfg_data,
    input  mnsp_pkg::t_cmd              i_cmd,
    output mnsp_pkg::t_stat             o_stat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mnsp_pkg::t_out_item         o_out_item
);
    import mnsp_pkg::*;

    t_in_item             r_item;
    logic [SLOT_W-1:0]    r_slot;
    logic [VADDR_W-1:0]   r_scan;
    logic [VADDR_W-1:0]   r_sweep;
    logic [SPAN_W-1:0]    r_count;
    logic [TICK_W-1:0]    r_loop;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [VWORD_BITS-1:0] v_rd_data;
    logic [VWORD_BITS-1:0] v_wr_data;
    logic [VADDR_W-1:0]    v_wr_addr;
    logic [VADDR_W-1:0]    v_rd_addr;
    logic                  v_wr_en;
    logic [DATA_W-1:0]     d_rd_data;
    logic [DATA_W-1:0]     d_wr_data;

    logic [INDEX_W-1:0]    d_on_index;
    logic [TICK_W-1:0]     d_start;
    logic [VEL_W-1:0]      d_vel;
    logic [VWORD_BITS-1:0] slot_mask;
    logic [VBIT_W-1:0]     hit_bit;
    logic [TICK_W-1:0]     eff_loop;
    logic [END_W-1:0]      ev_end;
    logic [END_W-1:0]      fl_end;
    logic                  is_flush;
    logic [3:0]            kind;
    t_out_item             span_item;
    t_in_item              in_item_masked;

    assign d_on_index = d_rd_data[DATA_W-1 -: INDEX_W];
    assign d_start    = d_rd_data[VEL_W +: TICK_W];
    assign d_vel      = d_rd_data[VEL_W-1:0];
    assign d_wr_data  = {r_item.event_index, r_item.tick, r_item.data_two};
    assign slot_mask  = VWORD_BITS'(1) << r_slot[VBIT_W-1:0];
    assign eff_loop   = (r_loop == '0) ? DEFAULT_LOOP : r_loop;
    assign is_flush   = (r_item.func == FUNC_FLUSH);
    assign kind       = r_item.status_byte[STATUS_W-1 -: 4];

    always_comb begin
        in_item_masked      = i_in_item;
        in_item_masked.tick = i_in_item.tick & TICK_MASK;
    end

    // first open slot of the scanned word
    always_comb begin
        hit_bit = '0;
        for (int b = VWORD_BITS - 1; b >= 0; b--) begin
            if (v_rd_data[b]) begin
                hit_bit = VBIT_W'(b);
            end
        end
    end

    assign v_rd_addr = i_cmd.rd_scan ? r_scan : r_slot[SLOT_W-1 -: VADDR_W];

    always_comb begin
        v_wr_en   = 1'b0;
        v_wr_addr = r_slot[SLOT_W-1 -: VADDR_W];
        v_wr_data = v_rd_data | slot_mask;
        if (i_cmd.sweep_wr) begin
            v_wr_en   = 1'b1;
            v_wr_addr = r_sweep;
            v_wr_data = '0;
        end else if (i_cmd.note_on_wr) begin
            v_wr_en   = 1'b1;
        end else if (i_cmd.emit_span) begin
            v_wr_en   = 1'b1;
            v_wr_data = v_rd_data & ~slot_mask;
        end
    end

    mnsp_ram #(
        .WIDTH (VWORD_BITS),
        .DEPTH (VWORDS)
    ) u_valid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (v_wr_en),
        .i_wr_addr (v_wr_addr),
        .i_wr_data (v_wr_data),
        .i_rd_addr (v_rd_addr),
        .o_rd_data (v_rd_data)
    );

    mnsp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (SLOTS)
    ) u_note_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.note_on_wr),
        .i_wr_addr (r_slot),
        .i_wr_data (d_wr_data),
        .i_rd_addr (r_slot),
        .o_rd_data (d_rd_data)
    );

    // wrapped note-off moves the end up by one loop
    assign ev_end = (r_item.tick <= d_start) ? END_W'(r_item.tick) + END_W'(eff_loop)
                                             : END_W'(r_item.tick);
    assign fl_end = (eff_loop <= d_start) ? END_W'(d_start) + END_W'(1)
                                          : END_W'(eff_loop);

    always_comb begin
        span_item.found        = 1'b1;
        span_item.on_index     = d_on_index;
        span_item.off_index    = is_flush ? '0 : r_item.event_index;
        span_item.off_implicit = is_flush;
        span_item.start_tick   = d_start;
        span_item.stop_tick    = is_flush ? fl_end : ev_end;
        span_item.channel      = r_slot[SLOT_W-1 -: CH_W];
        span_item.note_number  = r_slot[NOTE_W-1:0];
        span_item.velocity     = d_vel;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item      <= in_item_masked;
            r_slot      <= {i_in_item.status_byte[CH_W-1:0], i_in_item.data_one};
            r_scan      <= '0;
        end else begin
            if (i_cmd.slot_from_scan) begin
                r_slot <= {r_scan, hit_bit};
            end
            if (i_cmd.scan_next) begin
                r_scan <= r_scan + VADDR_W'(1);
            end
        end
        if (i_cmd.emit_span) begin
            r_out <= span_item;
        end else if (i_cmd.emit_none) begin
            r_out <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_count     <= '0;
            r_loop      <= DEFAULT_LOOP;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_start) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_wr) begin
                r_sweep <= r_sweep + VADDR_W'(1);
            end
            if (i_cmd.clear_start) begin
                r_count <= '0;
            end else if (i_cmd.emit_span) begin
                r_count <= r_count + SPAN_W'(1);
            end
            if (i_cfg_valid) begin
                r_loop <= i_cfg_data;
            end
            if (i_cmd.emit_span || i_cmd.emit_none) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.in_func    = i_in_item.func;
        o_stat.at_limit   = (r_count >= SPAN_W'(MAX_SPANS));
        o_stat.ev_ok      = (r_item.msg_len == MSG_LEN_FULL)
                          && ({1'b0, r_item.status_byte[CH_W-1:0]} < (CH_W+1)'(CHANNELS))
                          && ({1'b0, r_item.data_one} < (NOTE_W+1)'(NOTES_PER_CHANNEL))
                          && (r_count < SPAN_W'(MAX_SPANS));
        o_stat.note_on    = (kind == KIND_NOTE_ON) && (r_item.data_two != '0);
        o_stat.note_off   = (kind == KIND_NOTE_OFF)
                          || ((kind == KIND_NOTE_ON) && (r_item.data_two == '0));
        o_stat.slot_open  = |(v_rd_data & slot_mask);
        o_stat.word_hit   = |v_rd_data;
        o_stat.scan_last  = (r_scan == VADDR_W'(VWORDS - 1));
        o_stat.sweep_last = (r_sweep == VADDR_W'(VWORDS - 1));
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
endmodule

// ===== hdl/mnsp_ctrl.sv =====
// Controller: sequences table sweep, event read-modify-write and flush scan.
module mnsp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  mnsp_pkg::t_stat i_stat,
    output mnsp_pkg::t_cmd  o_cmd
);
    import mnsp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_stat.in_func)
                        FUNC_CLEAR: begin
                            o_cmd.clear_start = 1'b1;
                            n_state = ST_CLEAR;
                        end
                        FUNC_EVENT: n_state = ST_EV_READ;
                        FUNC_FLUSH: n_state = i_stat.at_limit ? ST_EMIT_NONE : ST_SCAN_READ;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_EV_READ: begin
                n_state = i_stat.ev_ok ? ST_EV_DONE : ST_IDLE;
            end
            ST_EV_DONE: begin
                if (i_stat.note_on) begin
                    o_cmd.note_on_wr = 1'b1;
                    n_state = ST_IDLE;
                end else if (i_stat.note_off && i_stat.slot_open) begin
                    n_state = ST_EMIT_SPAN;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_READ: begin
                o_cmd.rd_scan = 1'b1;
                n_state = ST_SCAN_CHECK;
            end
            ST_SCAN_CHECK: begin
                o_cmd.rd_scan = 1'b1;
                if (i_stat.word_hit) begin
                    o_cmd.slot_from_scan = 1'b1;
                    n_state = ST_FL_READ;
                end else if (i_stat.scan_last) begin
                    n_state = ST_EMIT_NONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = ST_SCAN_READ;
                end
            end
            ST_FL_READ: begin
                n_state = ST_EMIT_SPAN;
            end
            ST_EMIT_SPAN: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_span = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT_NONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_none = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== hdl/midi_note_span_pairer.sv =====
// Top level of the MIDI note span pairer: controller, datapath and channel hookup.
//
// Channels: i_in takes items (clear, MIDI event, flush), o_out gives span
// results, i_cfg writes the loop length and is always ready.
// A clear item empties the open-note table by sweeping its 128 valid words,
// one per cycle; items are not taken during the sweep. Reset starts the same
// sweep and sets the loop length to 384.
// An event item goes through accept, table read and update; a note-off
// that closes a note adds an emit step, which puts its result in the output
// register once that register is free.
// A flush item scans the valid words, each of 16 notes, in channel-then-note
// order, reading and then checking each word, and on a hit reads the note and
// emits its span; with no open note or at the span limit it emits an empty result.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, the block holds in its emit step once a
// second result is ready and resumes when the output register frees up.
module midi_note_span_pairer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mnsp_in_if.sink     i_in,
    mnsp_out_if.source  o_out,
    mnsp_cfg_if.sink    i_cfg
);
    import mnsp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    mnsp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mnsp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in.payload),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (o_out.payload)
    );
endmodule
